FILE: rtl/c8_pkg.sv
// Shared constants, types and helper functions of the CHIP-8 instruction core.
package c8_pkg;

	localparam int C8_MEMORY_BYTES   = 4096;
	localparam int C8_ADDR_W         = 12;
	localparam int C8_STACK_DEPTH    = 16;
	localparam int C8_SCREEN_ROWS    = 32;
	localparam int C8_SCREEN_COLUMNS = 64;
	localparam int C8_ROW_W          = $clog2(C8_SCREEN_ROWS);
	localparam int C8_COL_W          = $clog2(C8_SCREEN_COLUMNS);
	localparam logic [C8_ADDR_W-1:0] C8_DEFAULT_START = 12'h200;

	// Item modes.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_EXEC  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_ROW   = 2'd3;

	// Opcode groups (top nibble).
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEI  = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SE   = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNE  = 4'h9;
	localparam logic [3:0] OP_LDIX = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [15:0] OPC_CLS = 16'h00E0;
	localparam logic [15:0] OPC_RET = 16'h00EE;
	localparam logic [7:0]  KK_SKP  = 8'h9E;
	localparam logic [7:0]  KK_SKNP = 8'hA1;
	localparam logic [7:0]  KK_GDT  = 8'h07;
	localparam logic [7:0]  KK_WKEY = 8'h0A;
	localparam logic [7:0]  KK_SDT  = 8'h15;
	localparam logic [7:0]  KK_SST  = 8'h18;
	localparam logic [7:0]  KK_ADDI = 8'h1E;
	localparam logic [7:0]  KK_FONT = 8'h29;
	localparam logic [7:0]  KK_BCD  = 8'h33;
	localparam logic [7:0]  KK_STOR = 8'h55;
	localparam logic [7:0]  KK_LOAD = 8'h65;

	// Low nibble of the 8XYn group.
	localparam logic [3:0] ALU_N_MOV = 4'h0;
	localparam logic [3:0] ALU_N_OR  = 4'h1;
	localparam logic [3:0] ALU_N_AND = 4'h2;
	localparam logic [3:0] ALU_N_XOR = 4'h3;
	localparam logic [3:0] ALU_N_ADD = 4'h4;
	localparam logic [3:0] ALU_N_SUB = 4'h5;
	localparam logic [3:0] ALU_N_SHR = 4'h6;
	localparam logic [3:0] ALU_N_RSB = 4'h7;
	localparam logic [3:0] ALU_N_SHL = 4'hE;

	typedef enum logic [3:0] {
		ALU_PASS_B, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
		ALU_SUB, ALU_SHR, ALU_RSUB, ALU_SHL
	} alu_op_t;

	typedef struct packed {
		logic [7:0] res;
		logic       flag;
	} alu_res_t;

	// Decimal digits of a byte: hundreds, tens, ones, four bits each.
	function automatic logic [11:0] c8_bcd(input logic [7:0] v);
		logic [1:0]  h;
		logic [7:0]  r;
		logic [14:0] p;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		r = v - 8'(h * 8'd100);
		// Multiply by 205/2048 is exact division by ten below one hundred.
		p = 15'(r[6:0]) * 15'd205;
		t = p[14:11];
		o = r - 8'(t * 8'd10);
		return {2'b00, h, t, o[3:0]};
	endfunction

endpackage

FILE: rtl/c8_if.sv
// Handshake channels of the CHIP-8 instruction core: items, results and configuration.
interface c8_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [11:0] address;
	logic [7:0]  write_byte;
	logic [15:0] keypad_state;
	logic [7:0]  random_byte;
	modport source (output valid, mode, address, write_byte, keypad_state, random_byte,
		input ready);
	modport sink (input valid, mode, address, write_byte, keypad_state, random_byte,
		output ready);
endinterface

interface c8_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] display_row;
	logic [11:0] program_counter;
	logic [11:0] index_value;
	logic        sound_on;
	logic        waiting_key;
	logic        stack_fault;
	modport source (output valid, display_row, program_counter, index_value, sound_on,
		waiting_key, stack_fault, input ready);
	modport sink (input valid, display_row, program_counter, index_value, sound_on,
		waiting_key, stack_fault, output ready);
endinterface

interface c8_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] start_address;
	modport source (output valid, start_address, input ready);
	modport sink (input valid, start_address, output ready);
endinterface

FILE: rtl/c8_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/c8_alu.sv
// Shared 8-bit arithmetic and logic unit of the CHIP-8 core.
module c8_alu (
	input  logic            [7:0] a,
	input  logic            [7:0] b,
	input  c8_pkg::alu_op_t       op,
	output c8_pkg::alu_res_t      y
);
	import c8_pkg::*;

	logic [8:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		y = '0;
		unique case (op)
			ALU_PASS_B: y.res = b;
			ALU_OR:     y.res = a | b;
			ALU_AND:    y.res = a & b;
			ALU_XOR:    y.res = a ^ b;
			ALU_ADD: begin
				y.res  = sum[7:0];
				y.flag = sum[8];
			end
			ALU_SUB: begin
				y.res  = a - b;
				y.flag = (a >= b);
			end
			ALU_SHR: begin
				y.res  = {1'b0, a[7:1]};
				y.flag = a[0];
			end
			ALU_RSUB: begin
				y.res  = b - a;
				y.flag = (b >= a);
			end
			ALU_SHL: begin
				y.res  = {a[6:0], 1'b0};
				y.flag = a[7];
			end
			default: y = '0;
		endcase
	end
endmodule

FILE: rtl/chip8_instruction_core.sv
// CHIP-8 instruction core: sequencer, register file, frame store and main memory.
// After reset the core sweeps its 4096-byte memory to zero, one byte a cycle, and takes no
// word until the sweep ends. It then handles one word at a time: a memory write, tick or
// row read passes dispatch and finish, an instruction passes dispatch, fetch of two bytes
// through the single memory read port, two register reads, execute and finish, a draw adds
// a read and a write step per sprite row, BCD adds a write per digit, FX55 adds a write per
// register and FX65 a read and a write per register. A finished result sits in an output
// register while the next word is taken. The start address is the fixed default, loaded
// into the program counter at reset, so writes to it are taken and have no further effect.
module chip8_instruction_core #(
	parameter int STACK_DEPTH = c8_pkg::C8_STACK_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	c8_cmd_if.sink   cmd,
	c8_rsp_if.source rsp,
	c8_cfg_if.sink   cfg
);
	import c8_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SIW = $clog2(STACK_DEPTH);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_FETCH_HI, S_FETCH_LO, S_RDX, S_RDY, S_EXEC,
		S_DRAW_RD, S_DRAW_WR, S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WR, S_FINISH
	} state_t;

	state_t state_q;
	state_t exec_next;

	logic [C8_ADDR_W-1:0] clr_q;
	logic [1:0]  mode_q;
	logic [11:0] addr_q;
	logic [7:0]  wbyte_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q;
	logic [7:0]  op_hi_q, op_lo_q;
	logic [7:0]  vx_q, vy_q;
	logic [11:0] pc_q, i_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]  dt_q, st_q;
	logic [7:0]  v_q [16];
	logic [11:0] stack_q [STACK_DEPTH];
	logic [63:0] frame_q [C8_SCREEN_ROWS];
	logic [63:0] row_q;
	logic        wait_q, fault_q, hit_q;
	logic [3:0]  loop_q;

	logic        out_valid_q;
	logic [63:0] out_row_q;
	logic [11:0] out_pc_q, out_i_q;
	logic        out_snd_q, out_wait_q, out_fault_q;

	// Memory port.
	logic                 ram_we;
	logic [C8_ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]           ram_wdata, ram_rdata;

	c8_ram #(.WIDTH(8), .DEPTH(C8_MEMORY_BYTES)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Decode.
	logic [15:0] opc;
	logic [3:0]  nib, x, y, n;
	logic [7:0]  kk;
	logic [11:0] nnn, i_loop;
	assign opc    = {op_hi_q, op_lo_q};
	assign nib    = opc[15:12];
	assign x      = opc[11:8];
	assign y      = opc[7:4];
	assign n      = opc[3:0];
	assign kk     = opc[7:0];
	assign nnn    = opc[11:0];
	assign i_loop = i_q + {8'd0, loop_q};

	// Shared ALU.
	alu_op_t  alu_op;
	logic     alu_ok, alu_flagged;
	logic [7:0] alu_b;
	alu_res_t alu_y;

	always_comb begin
		alu_op      = ALU_XOR;
		alu_ok      = 1'b0;
		alu_flagged = 1'b0;
		alu_b       = vy_q;
		if (nib == OP_SEI || nib == OP_SNEI) begin
			alu_b = kk;
		end else if (nib == OP_ADDI) begin
			alu_b  = kk;
			alu_op = ALU_ADD;
		end else if (nib == OP_ALU) begin
			alu_ok = 1'b1;
			unique case (n)
				ALU_N_MOV: alu_op = ALU_PASS_B;
				ALU_N_OR:  alu_op = ALU_OR;
				ALU_N_AND: alu_op = ALU_AND;
				ALU_N_XOR: alu_op = ALU_XOR;
				ALU_N_ADD: begin alu_op = ALU_ADD;  alu_flagged = 1'b1; end
				ALU_N_SUB: begin alu_op = ALU_SUB;  alu_flagged = 1'b1; end
				ALU_N_SHR: begin alu_op = ALU_SHR;  alu_flagged = 1'b1; end
				ALU_N_RSB: begin alu_op = ALU_RSUB; alu_flagged = 1'b1; end
				ALU_N_SHL: begin alu_op = ALU_SHL;  alu_flagged = 1'b1; end
				default:   alu_ok = 1'b0;
			endcase
		end
	end

	c8_alu u_alu (
		.a  (vx_q),
		.b  (alu_b),
		.op (alu_op),
		.y  (alu_y)
	);

	logic alu_eq;
	assign alu_eq = (alu_y.res == 8'd0);

	// Key state and lowest pressed key.
	logic       key_hit, key_found;
	logic [3:0] key_idx;
	assign key_hit = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];

	always_comb begin
		key_found = 1'b0;
		key_idx   = '0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) begin
				key_found = 1'b1;
				key_idx   = 4'(k);
			end
		end
	end

	// Decimal digits.
	logic [11:0] bcd_w;
	logic [7:0]  bcd_byte;
	assign bcd_w = c8_bcd(vx_q);
	always_comb begin
		unique case (loop_q[1:0])
			2'd0:    bcd_byte = {4'd0, bcd_w[11:8]};
			2'd1:    bcd_byte = {4'd0, bcd_w[7:4]};
			default: bcd_byte = {4'd0, bcd_w[3:0]};
		endcase
	end

	// Sprite row placed at column x0 with wraparound.
	logic [C8_ROW_W-1:0] draw_row;
	logic [127:0]        mask_wide;
	logic [63:0]         mask, cur_row;
	assign draw_row  = C8_ROW_W'(vy_q[C8_ROW_W-1:0] + C8_ROW_W'(loop_q));
	assign mask_wide = {ram_rdata, 56'd0, ram_rdata, 56'd0} >> vx_q[C8_COL_W-1:0];
	assign mask      = mask_wide[63:0];
	assign cur_row   = frame_q[draw_row];

	logic stack_full, stack_empty;
	assign stack_full  = (sp_q == SPW'(STACK_DEPTH));
	assign stack_empty = (sp_q == '0);

	// Multi-cycle instructions leave the execute step for their own loop.
	always_comb begin
		exec_next = S_FINISH;
		if (nib == OP_DRW && n != 4'd0) begin
			exec_next = S_DRAW_RD;
		end else if (nib == OP_MISC) begin
			if (kk == KK_BCD) begin
				exec_next = S_BCD;
			end else if (kk == KK_STOR) begin
				exec_next = S_STORE;
			end else if (kk == KK_LOAD) begin
				exec_next = S_LOAD_RD;
			end
		end
	end

	// Memory port steering.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_loop;
		ram_wdata = v_q[loop_q];
		ram_raddr = i_loop;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_DISPATCH: begin
				ram_we    = (mode_q == MODE_WRITE);
				ram_waddr = addr_q;
				ram_wdata = wbyte_q;
				ram_raddr = pc_q;
			end
			S_FETCH_HI: ram_raddr = pc_q + 12'd1;
			S_BCD: begin
				ram_we    = 1'b1;
				ram_wdata = bcd_byte;
			end
			S_STORE: ram_we = 1'b1;
			default: ;
		endcase
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			mode_q      <= '0;
			addr_q      <= '0;
			wbyte_q     <= '0;
			keys_q      <= '0;
			rnd_q       <= '0;
			op_hi_q     <= '0;
			op_lo_q     <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			pc_q        <= C8_DEFAULT_START;
			i_q         <= '0;
			sp_q        <= '0;
			dt_q        <= '0;
			st_q        <= '0;
			row_q       <= '0;
			wait_q      <= 1'b0;
			fault_q     <= 1'b0;
			hit_q       <= 1'b0;
			loop_q      <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_pc_q    <= '0;
			out_i_q     <= '0;
			out_snd_q   <= 1'b0;
			out_wait_q  <= 1'b0;
			out_fault_q <= 1'b0;
			for (int r = 0; r < 16; r++) v_q[r] <= '0;
			for (int r = 0; r < C8_SCREEN_ROWS; r++) frame_q[r] <= '0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == C8_ADDR_W'(C8_MEMORY_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.valid) begin
						mode_q  <= cmd.mode;
						addr_q  <= cmd.address;
						wbyte_q <= cmd.write_byte;
						keys_q  <= cmd.keypad_state;
						rnd_q   <= cmd.random_byte;
						row_q   <= '0;
						wait_q  <= 1'b0;
						fault_q <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (mode_q)
						MODE_WRITE: state_q <= S_FINISH;
						MODE_EXEC:  state_q <= S_FETCH_HI;
						MODE_TICK: begin
							if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
							if (st_q != 8'd0) st_q <= st_q - 8'd1;
							state_q <= S_FINISH;
						end
						default: begin
							row_q   <= frame_q[addr_q[C8_ROW_W-1:0]];
							state_q <= S_FINISH;
						end
					endcase
				end
				S_FETCH_HI: begin
					op_hi_q <= ram_rdata;
					state_q <= S_FETCH_LO;
				end
				S_FETCH_LO: begin
					op_lo_q <= ram_rdata;
					pc_q    <= pc_q + 12'd2;
					state_q <= S_RDX;
				end
				S_RDX: begin
					vx_q    <= v_q[x];
					state_q <= S_RDY;
				end
				S_RDY: begin
					// BNNN takes V0 in place of Vy.
					vy_q    <= (nib == OP_JPV0) ? v_q[0] : v_q[y];
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= exec_next;
					loop_q  <= '0;
					hit_q   <= 1'b0;
					unique case (nib)
						OP_SYS: begin
							if (opc == OPC_CLS) begin
								for (int r = 0; r < C8_SCREEN_ROWS; r++) frame_q[r] <= '0;
							end else if (opc == OPC_RET) begin
								if (stack_empty) begin
									fault_q <= 1'b1;
								end else begin
									sp_q <= sp_q - 1'b1;
									pc_q <= stack_q[SIW'(sp_q - 1'b1)];
								end
							end
						end
						OP_JP: pc_q <= nnn;
						OP_CALL: begin
							if (stack_full) begin
								fault_q <= 1'b1;
							end else begin
								sp_q <= sp_q + 1'b1;
								pc_q <= nnn;
							end
						end
						OP_SEI, OP_SE: if (alu_eq) pc_q <= pc_q + 12'd2;
						OP_SNEI, OP_SNE: if (!alu_eq) pc_q <= pc_q + 12'd2;
						OP_LDI:  v_q[x] <= kk;
						OP_ADDI: v_q[x] <= alu_y.res;
						OP_ALU: begin
							// The flag lands after Vx, so it wins when X is F.
							if (alu_ok && !(alu_flagged && x == 4'hF)) v_q[x] <= alu_y.res;
							if (alu_flagged) v_q[15] <= {7'd0, alu_y.flag};
						end
						OP_LDIX: i_q <= nnn;
						OP_JPV0: pc_q <= nnn + {4'd0, vy_q};
						OP_RND:  v_q[x] <= rnd_q & kk;
						OP_DRW: begin
							if (n == 4'd0) begin
								v_q[15] <= '0;
							end
						end
						OP_KEY: begin
							if ((kk == KK_SKP && key_hit) || (kk == KK_SKNP && !key_hit)) begin
								pc_q <= pc_q + 12'd2;
							end
						end
						default: begin
							unique case (kk)
								KK_GDT: v_q[x] <= dt_q;
								KK_WKEY: begin
									if (key_found) begin
										v_q[x] <= {4'd0, key_idx};
									end else begin
										pc_q   <= pc_q - 12'd2;
										wait_q <= 1'b1;
									end
								end
								KK_SDT:  dt_q <= vx_q;
								KK_SST:  st_q <= vx_q;
								KK_ADDI: i_q <= i_q + {4'd0, vx_q};
								KK_FONT: i_q <= 12'({4'd0, vx_q} * 12'd5);
								default: ;
							endcase
						end
					endcase
				end
				S_DRAW_RD: state_q <= S_DRAW_WR;
				S_DRAW_WR: begin
					frame_q[draw_row] <= cur_row ^ mask;
					if (loop_q == n - 4'd1) begin
						v_q[15] <= {7'd0, hit_q | (|(cur_row & mask))};
						state_q <= S_FINISH;
					end else begin
						hit_q   <= hit_q | (|(cur_row & mask));
						loop_q  <= loop_q + 4'd1;
						state_q <= S_DRAW_RD;
					end
				end
				S_BCD: begin
					loop_q <= loop_q + 4'd1;
					if (loop_q == 4'd2) state_q <= S_FINISH;
				end
				S_STORE: begin
					loop_q <= loop_q + 4'd1;
					if (loop_q == x) begin
						i_q     <= i_loop + 12'd1;
						state_q <= S_FINISH;
					end
				end
				S_LOAD_RD: state_q <= S_LOAD_WR;
				S_LOAD_WR: begin
					v_q[loop_q] <= ram_rdata;
					loop_q      <= loop_q + 4'd1;
					if (loop_q == x) begin
						i_q     <= i_loop + 12'd1;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_LOAD_RD;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_row_q   <= row_q;
						out_pc_q    <= pc_q;
						out_i_q     <= i_q;
						out_snd_q   <= (st_q != 8'd0);
						out_wait_q  <= wait_q;
						out_fault_q <= fault_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Return stack: written by a call that finds room.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && nib == OP_CALL && !stack_full) begin
			stack_q[sp_q[SIW-1:0]] <= pc_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.display_row     = out_row_q;
	assign rsp.program_counter = out_pc_q;
	assign rsp.index_value     = out_i_q;
	assign rsp.sound_on        = out_snd_q;
	assign rsp.waiting_key     = out_wait_q;
	assign rsp.stack_fault     = out_fault_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack level beyond depth");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("word accepted while busy");
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !cmd.ready)
		else $error("word accepted during memory clear");
	a_wait_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.waiting_key && rsp.stack_fault))
		else $error("key wait and stack fault together");
	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BCD |-> loop_q <= 4'd2)
		else $error("BCD step out of range");
endmodule

FILE: tb/tb.sv
// Self-checking testbench of the CHIP-8 instruction core: random programs, timer ticks and row reads.
module tb;
	import c8_pkg::*;

	typedef struct packed {
		logic        hold;
		logic [1:0]  mode;
		logic [11:0] address;
		logic [7:0]  data;
		logic [15:0] keys;
		logic [7:0]  rnd;
	} word_t;

	typedef struct packed {
		logic [63:0] row;
		logic [11:0] pc;
		logic [11:0] idx;
		logic        snd;
		logic        waitk;
		logic        fault;
	} outcome_t;

	localparam int PLAN = 0;
	localparam int CHECK = 1;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	c8_cmd_if cmd_ch();
	c8_rsp_if rsp_ch();
	c8_cfg_if cfg_ch();

	chip8_instruction_core DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	// Two copies of the core state: one steers program generation, one checks the results.
	logic [7:0]  mem_s [2][C8_MEMORY_BYTES];
	logic [7:0]  vreg [2][16];
	logic [11:0] ireg [2];
	logic [11:0] pcr [2];
	logic [11:0] rstack [2][C8_STACK_DEPTH];
	logic [4:0]  depth [2];
	logic [7:0]  dtim [2];
	logic [7:0]  stim [2];
	logic [63:0] frame [2][C8_SCREEN_ROWS];

	word_t    pending_words[$];
	outcome_t expected_outcomes[$];
	word_t    cur;
	logic     cmd_fired;
	logic     running;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       errors;
	int       words_sent;
	int       outcomes_seen;
	int       cfg_writes;
	int       quiet_cycles;

	function automatic void clear_core(input int c);
		for (int i = 0; i < C8_MEMORY_BYTES; i++) mem_s[c][i] = 8'h00;
		for (int i = 0; i < 16; i++) vreg[c][i] = 8'h00;
		for (int i = 0; i < C8_STACK_DEPTH; i++) rstack[c][i] = 12'h000;
		for (int i = 0; i < C8_SCREEN_ROWS; i++) frame[c][i] = 64'h0;
		ireg[c] = 12'h000;
		pcr[c] = C8_DEFAULT_START;
		depth[c] = 5'd0;
		dtim[c] = 8'h00;
		stim[c] = 8'h00;
	endfunction

	function automatic void run_opcode(input int c, input word_t w, inout outcome_t r);
		logic [15:0] op;
		logic [11:0] a;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [7:0]  kk;
		logic [7:0]  va;
		logic [7:0]  vb;
		logic [7:0]  res;
		logic        flag;
		logic        wr;
		logic        hit;
		logic [7:0]  line;
		logic [4:0]  rw;
		logic [5:0]  col;
		logic        kp;
		int          k;
		a = pcr[c] + 12'd1;
		op = {mem_s[c][pcr[c]], mem_s[c][a]};
		x = op[11:8];
		y = op[7:4];
		kk = op[7:0];
		va = vreg[c][x];
		vb = vreg[c][y];
		pcr[c] = pcr[c] + 12'd2;
		case (op[15:12])
			OP_SYS: begin
				if (op == OPC_CLS) begin
					for (int i = 0; i < C8_SCREEN_ROWS; i++) frame[c][i] = 64'h0;
				end else if (op == OPC_RET) begin
					if (depth[c] == 0) r.fault = 1'b1;
					else begin
						depth[c] = depth[c] - 5'd1;
						pcr[c] = rstack[c][depth[c]];
					end
				end
			end
			OP_JP: pcr[c] = op[11:0];
			OP_CALL: begin
				if (depth[c] >= C8_STACK_DEPTH) r.fault = 1'b1;
				else begin
					rstack[c][depth[c]] = pcr[c];
					depth[c] = depth[c] + 5'd1;
					pcr[c] = op[11:0];
				end
			end
			OP_SEI: if (va == kk) pcr[c] = pcr[c] + 12'd2;
			OP_SNEI: if (va != kk) pcr[c] = pcr[c] + 12'd2;
			OP_SE: if (va == vb) pcr[c] = pcr[c] + 12'd2;
			OP_LDI: vreg[c][x] = kk;
			OP_ADDI: vreg[c][x] = va + kk;
			OP_ALU: begin
				wr = 1'b1;
				res = 8'h00;
				flag = 1'b0;
				case (op[3:0])
					ALU_N_MOV: begin vreg[c][x] = vb; wr = 1'b0; end
					ALU_N_OR:  begin vreg[c][x] = va | vb; wr = 1'b0; end
					ALU_N_AND: begin vreg[c][x] = va & vb; wr = 1'b0; end
					ALU_N_XOR: begin vreg[c][x] = va ^ vb; wr = 1'b0; end
					ALU_N_ADD: {flag, res} = {1'b0, va} + {1'b0, vb};
					ALU_N_SUB: begin res = va - vb; flag = va >= vb; end
					ALU_N_SHR: begin res = va >> 1; flag = va[0]; end
					ALU_N_RSB: begin res = vb - va; flag = vb >= va; end
					ALU_N_SHL: begin res = va << 1; flag = va[7]; end
					default: wr = 1'b0;
				endcase
				// The flag goes in after the result, so it wins when X is F.
				if (wr) begin
					vreg[c][x] = res;
					vreg[c][15] = {7'd0, flag};
				end
			end
			OP_SNE: if (va != vb) pcr[c] = pcr[c] + 12'd2;
			OP_LDIX: ireg[c] = op[11:0];
			OP_JPV0: pcr[c] = op[11:0] + {4'h0, vreg[c][0]};
			OP_RND: vreg[c][x] = w.rnd & kk;
			OP_DRW: begin
				hit = 1'b0;
				for (int i = 0; i < op[3:0]; i++) begin
					a = ireg[c] + 12'(i);
					line = mem_s[c][a];
					rw = vb[4:0] + 5'(i);
					for (int b = 0; b < 8; b++) begin
						if (line[7 - b]) begin
							col = va[5:0] + 6'(b);
							if (frame[c][rw][63 - col]) hit = 1'b1;
							frame[c][rw][63 - col] = ~frame[c][rw][63 - col];
						end
					end
				end
				vreg[c][15] = {7'd0, hit};
			end
			OP_KEY: begin
				kp = (va < 8'd16) ? w.keys[va[3:0]] : 1'b0;
				if ((kk == KK_SKP && kp) || (kk == KK_SKNP && !kp)) pcr[c] = pcr[c] + 12'd2;
			end
			default: begin
				case (kk)
					KK_GDT: vreg[c][x] = dtim[c];
					KK_WKEY: begin
						k = 16;
						for (int i = 15; i >= 0; i--) if (w.keys[i]) k = i;
						if (k == 16) begin
							pcr[c] = pcr[c] - 12'd2;
							r.waitk = 1'b1;
						end else vreg[c][x] = 8'(k);
					end
					KK_SDT: dtim[c] = va;
					KK_SST: stim[c] = va;
					KK_ADDI: ireg[c] = ireg[c] + {4'h0, va};
					KK_FONT: ireg[c] = 12'(va * 5);
					KK_BCD: begin
						mem_s[c][ireg[c]] = 8'(va / 100);
						a = ireg[c] + 12'd1;
						mem_s[c][a] = 8'((va / 10) % 10);
						a = ireg[c] + 12'd2;
						mem_s[c][a] = 8'(va % 10);
					end
					KK_STOR: begin
						for (int i = 0; i <= x; i++) begin
							a = ireg[c] + 12'(i);
							mem_s[c][a] = vreg[c][i];
						end
						ireg[c] = ireg[c] + 12'(x) + 12'd1;
					end
					KK_LOAD: begin
						for (int i = 0; i <= x; i++) begin
							a = ireg[c] + 12'(i);
							vreg[c][i] = mem_s[c][a];
						end
						ireg[c] = ireg[c] + 12'(x) + 12'd1;
					end
					default: ;
				endcase
			end
		endcase
	endfunction

	function automatic outcome_t step_core(input int c, input word_t w);
		outcome_t r;
		r = '0;
		case (w.mode)
			MODE_WRITE: mem_s[c][w.address] = w.data;
			MODE_EXEC:  run_opcode(c, w, r);
			MODE_TICK: begin
				if (dtim[c] != 0) dtim[c] = dtim[c] - 8'd1;
				if (stim[c] != 0) stim[c] = stim[c] - 8'd1;
			end
			default: r.row = frame[c][w.address[4:0]];
		endcase
		r.pc = pcr[c];
		r.idx = ireg[c];
		r.snd = stim[c] != 0;
		return r;
	endfunction

	function automatic logic [15:0] pick_keys();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'h0001 << $urandom_range(15);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_word(input logic [1:0] mode, input logic [11:0] address,
		input logic [7:0] data, input logic [15:0] keys, input logic hold);
		word_t w;
		outcome_t r;
		w.hold = hold;
		w.mode = mode;
		w.address = address;
		w.data = data;
		w.keys = keys;
		w.rnd = 8'($urandom);
		r = step_core(PLAN, w);
		pending_words = {pending_words, w};
	endtask

	// An instruction is stored at the planned program counter, then executed.
	task automatic queue_opcode(input logic [15:0] op, input logic [15:0] keys);
		queue_word(MODE_WRITE, pcr[PLAN], op[15:8], 16'($urandom), 1'b0);
		queue_word(MODE_WRITE, pcr[PLAN] + 12'd1, op[7:0], 16'($urandom), 1'b0);
		queue_word(MODE_EXEC, 12'($urandom), 8'($urandom), keys, 1'b0);
	endtask

	function automatic logic [15:0] pick_opcode();
		logic [15:0] op;
		logic [7:0]  misc_kk [9];
		misc_kk = '{KK_GDT, KK_WKEY, KK_SDT, KK_SST, KK_ADDI, KK_FONT, KK_BCD, KK_STOR,
			KK_LOAD};
		op = 16'($urandom);
		case (op[15:12])
			OP_SYS: begin
				case ($urandom_range(3))
					0: op = OPC_CLS;
					1, 2: op = OPC_RET;
					default: ;
				endcase
			end
			OP_ALU: if ($urandom_range(7) != 0) op[3:0] = 4'($urandom_range(8)) == 4'd8 ?
				ALU_N_SHL : 4'($urandom_range(7));
			OP_DRW: if ($urandom_range(3) == 0) op[3:0] = 4'hF;
			OP_KEY: if ($urandom_range(7) != 0) op[7:0] = $urandom_range(1) ? KK_SKP : KK_SKNP;
			OP_MISC: if ($urandom_range(7) != 0) op[7:0] = misc_kk[$urandom_range(8)];
			default: ;
		endcase
		return op;
	endfunction

	task automatic queue_directed();
		queue_word(MODE_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 1'b0);
		queue_word(MODE_WRITE, 12'h000, 8'h00, 16'h0000, 1'b0);
		queue_opcode({OP_LDI, 4'h1, 8'hFF}, 16'h0000);
		queue_opcode({OP_LDI, 4'hF, 8'h01}, 16'h0000);
		queue_opcode({OP_ALU, 4'hF, 4'h1, ALU_N_ADD}, 16'h0000);
		queue_opcode({OP_ALU, 4'h2, 4'h1, ALU_N_SUB}, 16'h0000);
		queue_opcode({OP_ALU, 4'hF, 4'h1, ALU_N_SHL}, 16'h0000);
		queue_opcode({OP_ALU, 4'h1, 4'h3, ALU_N_SHR}, 16'h0000);
		queue_opcode({OP_ALU, 4'h3, 4'h1, ALU_N_RSB}, 16'h0000);
		queue_opcode({OP_MISC, 4'h4, KK_WKEY}, 16'h0000);
		queue_opcode({OP_MISC, 4'h4, KK_WKEY}, 16'h8000);
		queue_opcode({OP_KEY, 4'h1, KK_SKP}, 16'hFFFF);
		queue_opcode({OP_LDI, 4'h5, 8'h3F}, 16'h0000);
		queue_opcode({OP_LDI, 4'h6, 8'hFF}, 16'h0000);
		queue_opcode({OP_LDIX, 12'hFFE}, 16'h0000);
		queue_opcode({OP_DRW, 4'h5, 4'h6, 4'hF}, 16'h0000);
		queue_opcode({OP_DRW, 4'h5, 4'h6, 4'h0}, 16'h0000);
		queue_word(MODE_ROW, 12'hFFF, 8'h00, 16'h0000, 1'b0);
		queue_opcode({OP_MISC, 4'h1, KK_BCD}, 16'h0000);
		queue_opcode({OP_MISC, 4'hF, KK_STOR}, 16'h0000);
		queue_opcode({OP_MISC, 4'h6, KK_SST}, 16'h0000);
		queue_word(MODE_TICK, 12'h000, 8'h00, 16'h0000, 1'b0);
		queue_opcode({OP_SYS, 12'h0EE}, 16'h0000);
		queue_opcode({OP_JP, 12'hFFF}, 16'h0000);
		queue_opcode({OP_SYS, 12'h0E0}, 16'h0000);
	endtask

	task automatic queue_random(input int count, input int hold_at);
		int start;
		start = pending_words.size();
		while (pending_words.size() - start < count) begin
			if (hold_at >= 0 && pending_words.size() - start >= hold_at) begin
				queue_word(MODE_TICK, 12'($urandom), 8'($urandom), 16'($urandom), 1'b1);
				hold_at = -1;
			end
			case ($urandom_range(19))
				0, 1: queue_word(MODE_TICK, 12'($urandom), 8'($urandom), 16'($urandom), 1'b0);
				2, 3: queue_word(MODE_ROW, 12'($urandom), 8'($urandom), 16'($urandom), 1'b0);
				4: queue_word(MODE_WRITE, 12'($urandom), 8'($urandom), 16'($urandom), 1'b0);
				5: queue_word(MODE_EXEC, 12'($urandom), 8'($urandom), pick_keys(), 1'b0);
				6: begin
					// Nested calls past the stack limit, then returns past empty.
					for (int i = 0; i < C8_STACK_DEPTH + 2; i++)
						queue_opcode({OP_CALL, 12'($urandom)}, pick_keys());
					for (int i = 0; i < C8_STACK_DEPTH + 2; i++)
						queue_opcode(OPC_RET, pick_keys());
				end
				default: queue_opcode(pick_opcode(), pick_keys());
			endcase
		end
	endtask

	task automatic write_start(input logic [11:0] value);
		@(negedge clk);
		cfg_ch.start_address <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || cmd_ch.valid || expected_outcomes.size() != 0)
			@(negedge clk);
		// Extra cycles follow once every result has come back; the core is idle by then.
		repeat (100) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: a new word goes out at the falling edge once the previous one is taken.
	always @(negedge clk) begin
		if (running && (!cmd_ch.valid || cmd_fired)) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				!(pending_words[0].hold && expected_outcomes.size() != 0)) begin
				cur <= pending_words.pop_front();
				cmd_ch.valid <= 1'b1;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
		if (running) rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct;
	end

	always_comb begin
		cmd_ch.mode = cur.mode;
		cmd_ch.address = cur.address;
		cmd_ch.write_byte = cur.data;
		cmd_ch.keypad_state = cur.keys;
		cmd_ch.random_byte = cur.rnd;
	end

	// Monitor: predicts on every taken word and checks every returned word.
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		cmd_fired <= cmd_ch.valid && cmd_ch.ready;
		if (cmd_ch.valid && cmd_ch.ready) begin
			expected_outcomes = {expected_outcomes, step_core(CHECK, cur)};
			words_sent++;
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			outcomes_seen++;
			got = {rsp_ch.display_row, rsp_ch.program_counter, rsp_ch.index_value,
				rsp_ch.sound_on, rsp_ch.waiting_key, rsp_ch.stack_fault};
			if (expected_outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word %h", $realtime, got);
			end else begin
				want = expected_outcomes.pop_front();
				if (got.row !== want.row) begin
					errors++;
					$display("%0t: display_row expected %h actual %h", $realtime, want.row, got.row);
				end
				if (got.pc !== want.pc) begin
					errors++;
					$display("%0t: program_counter expected %h actual %h", $realtime, want.pc, got.pc);
				end
				if (got.idx !== want.idx) begin
					errors++;
					$display("%0t: index_value expected %h actual %h", $realtime, want.idx, got.idx);
				end
				if (got.snd !== want.snd) begin
					errors++;
					$display("%0t: sound_on expected %b actual %b", $realtime, want.snd, got.snd);
				end
				if (got.waitk !== want.waitk) begin
					errors++;
					$display("%0t: waiting_key expected %b actual %b", $realtime, want.waitk,
						got.waitk);
				end
				if (got.fault !== want.fault) begin
					errors++;
					$display("%0t: stack_fault expected %b actual %b", $realtime, want.fault,
						got.fault);
				end
			end
		end
	end

	// Watchdog: the clearing sweep after reset fits well inside the limit.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready) || !running)
			quiet_cycles <= 0;
		else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("Verification failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		logic [11:0] starts [4];
		starts = '{12'h000, 12'hFFF, 12'($urandom), C8_DEFAULT_START};
		arst_n = 1'b0;
		running = 1'b0;
		cur = '0;
		cmd_fired = 1'b0;
		cmd_ch.valid = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.start_address = 12'h000;
		errors = 0;
		words_sent = 0;
		outcomes_seen = 0;
		cfg_writes = 0;
		quiet_cycles = 0;
		send_idle_pct = 25;
		recv_idle_pct = 48;
		clear_core(PLAN);
		clear_core(CHECK);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		running = 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 25 : ((ph == 1) ? 48 : 0);
			recv_idle_pct = (ph == 0) ? 48 : ((ph == 1) ? 25 : 0);
			write_start(starts[ph]);
			if (ph == 0) queue_directed();
			queue_random(500, (ph == 1) ? 200 : -1);
			drain();
		end
		write_start(starts[3]);
		repeat (20) @(negedge clk);
		$display("Covered %0d words, %0d results and %0d start address writes,", words_sent,
			outcomes_seen, cfg_writes);
		$display("across all opcode groups, stack limits, key waits, wrapped draws and ticks.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
